[rtl/barometric_pressure_compensation_macros.svh]
// ---------------------------------------------------------------------------
// Barometric pressure compensation assertion macros
// Shared property forms for the checker, clocked on clk, reset rst.
// ---------------------------------------------------------------------------
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH

// same-cycle implication, off during reset
`define BPC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, always active
`define BPC_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bpc_pkg.sv]
// ---------------------------------------------------------------------------
// Barometric pressure compensation package
// Register indexes, compensation constants, status codes and result type.
// ---------------------------------------------------------------------------
package bpc_pkg;

  typedef enum logic [1:0] {
    CFG_WORD_A = 2'd0,
    CFG_WORD_B = 2'd1,
    CFG_WORD_C = 2'd2
  } cfg_index_t;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_DIV_ZERO = 1'b1;

  localparam int B5_OFFSET   = 4000;
  localparam int P_SQ_COEF   = 3038;
  localparam int P_LIN_COEF  = 7357;   // applied with negative sign
  localparam int P_OFFSET    = 3791;
  localparam int B7_SCALE    = 50000;
  localparam int B4_BIAS     = 32768;
  localparam int TEMP_ROUND  = 8;
  localparam int TEMP_MAX    = 32767;
  localparam int TEMP_MIN    = -32768;
  localparam int PRESS_MAX   = 262143;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [17:0]        pressure_pa;
    logic               status;
  } result_t;

endpackage

[rtl/bpc_intf.sv]
// ---------------------------------------------------------------------------
// Barometric pressure compensation channel interfaces
// Sample, result and configuration channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface bpc_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [23:0] raw_pressure;

  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bpc_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_tenths;
  logic [17:0]        pressure_pa;
  logic               status;

  modport source (output valid, output temperature_tenths, output pressure_pa,
                  output status, input ready);
  modport sink   (input valid, input temperature_tenths, input pressure_pa,
                  input status, output ready);
endinterface

interface bpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/barometric_pressure_compensation.sv]
// Throughput: one sample per cycle while the output queue is not full;
// the two bit-per-stage dividers (27 and 33 stages) set the depth, not
// the rate. A two-entry output queue keeps the pipeline moving while a
// result waits. Reset (rst, synchronous) clears all valid bits, the
// queue and the coefficient registers; no result is pending afterwards.
// ---------------------------------------------------------------------------
// Barometric pressure compensation
// Integer temperature and pressure compensation from raw sensor words.
// ---------------------------------------------------------------------------
module barometric_pressure_compensation (
  input  logic clk,
  input  logic rst,
  bpc_sample_if.sink   sample,
  bpc_result_if.source result,
  bpc_cfg_if.sink      cfg
);

  // coefficient registers
  logic [63:0] coef_a;
  logic [63:0] coef_b;
  logic [31:0] coef_c;   // MB is not used by the formulas

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= '0;
      coef_b <= '0;
      coef_c <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bpc_pkg::CFG_WORD_A: coef_a <= cfg.data;
        bpc_pkg::CFG_WORD_B: coef_b <= cfg.data;
        bpc_pkg::CFG_WORD_C: coef_c <= cfg.data[31:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;

  assign ac1 = coef_a[63:48];
  assign ac2 = coef_a[47:32];
  assign ac3 = coef_a[31:16];
  assign ac4 = coef_a[15:0];
  assign ac5 = coef_b[63:48];
  assign ac6 = coef_b[47:32];
  assign b1  = coef_b[31:16];
  assign b2  = coef_b[15:0];
  assign mc  = coef_c[31:16];
  assign md  = coef_c[15:0];

  // pipeline advance and output queue
  logic                adv;
  logic [1:0]          q_count;
  logic                q_wr, q_rd;
  logic                push, pop;
  bpc_pkg::result_t    q_mem [2];
  bpc_pkg::result_t    res_next;

  assign adv          = (q_count != 2'd2);
  assign sample.ready = adv;

  // ---- stage A: (UT - AC6) * AC5
  logic signed [16:0] a_dif;
  logic signed [33:0] a_prod_next;
  logic               a_v;
  logic signed [33:0] a_prod;
  logic [15:0]        a_up;

  assign a_dif       = $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, ac6});
  assign a_prod_next = 34'(a_dif) * 34'($signed({1'b0, ac5}));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_prod <= a_prod_next;
      a_up   <= sample.raw_pressure[23:8];
    end
  end

  // ---- stage B: X1, divisor X1 + MD, dividend MC * 2048 as magnitudes
  logic signed [18:0] b_x1_next;
  logic signed [19:0] b_d1;
  logic signed [26:0] b_num;
  logic               b_v, b_neg, b_z;
  logic signed [18:0] b_x1;
  logic [26:0]        b_nmag;
  logic [19:0]        b_dmag;
  logic [15:0]        b_up;

  assign b_x1_next = a_prod[33:15];
  assign b_d1      = 20'(b_x1_next) + 20'(md);
  assign b_num     = $signed({mc, 11'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_x1   <= b_x1_next;
      b_nmag <= b_num[26] ? 27'(-b_num) : b_num;
      b_dmag <= b_d1[19] ? 20'(-b_d1) : b_d1;
      b_neg  <= b_num[26] ^ b_d1[19];
      b_z    <= (b_d1 == '0);
      b_up   <= a_up;
    end
  end

  // ---- divider 1: X2 magnitude
  localparam int S1W = 19 + 1 + 1 + 16;
  logic               d1_v;
  logic [26:0]        d1_q;
  logic [S1W-1:0]     d1_side;
  logic signed [18:0] d1_x1;
  logic               d1_neg, d1_z;
  logic [15:0]        d1_up;

  bpc_div #(.NW(27), .DW(20), .SW(S1W)) u_div_temp (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (b_v),
    .num      (b_nmag),
    .den      (b_z ? 20'd1 : b_dmag),
    .side_in  ({b_x1, b_neg, b_z, b_up}),
    .out_valid(d1_v),
    .quo      (d1_q),
    .side_out (d1_side)
  );

  assign {d1_x1, d1_neg, d1_z, d1_up} = d1_side;

  // ---- stage C: B5, temperature, B6
  logic signed [27:0] c_x2;
  logic signed [28:0] c_b5, c_tsum;
  logic signed [24:0] c_tq;
  logic signed [15:0] c_temp_next;
  logic               c_v, c_z;
  logic signed [29:0] c_b6;
  logic signed [15:0] c_temp;
  logic [15:0]        c_up;

  assign c_x2   = d1_neg ? -$signed({1'b0, d1_q}) : $signed({1'b0, d1_q});
  assign c_b5   = 29'(d1_x1) + 29'(c_x2);
  assign c_tsum = c_b5 + 29'(bpc_pkg::TEMP_ROUND);
  assign c_tq   = c_tsum[28:4];

  always_comb begin
    if (c_tq > 25'(bpc_pkg::TEMP_MAX)) begin
      c_temp_next = 16'(bpc_pkg::TEMP_MAX);
    end else if (c_tq < 25'(bpc_pkg::TEMP_MIN)) begin
      c_temp_next = 16'(bpc_pkg::TEMP_MIN);
    end else begin
      c_temp_next = c_tq[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_b6   <= 30'(c_b5) - 30'(bpc_pkg::B5_OFFSET);
      c_temp <= c_temp_next;
      c_z    <= d1_z;
      c_up   <= d1_up;
    end
  end

  // ---- stage D: B6 squared, AC2 * B6, AC3 * B6
  logic signed [59:0] d_sq_full;
  logic signed [45:0] d_pa2, d_pa3;
  logic               d_v, d_z;
  logic [45:0]        d_sq;
  logic signed [34:0] d_ac2t;
  logic signed [32:0] d_ac3t;
  logic signed [15:0] d_temp;
  logic [15:0]        d_up;

  assign d_sq_full = 60'(c_b6) * 60'(c_b6);
  assign d_pa2     = 46'(ac2) * 46'(c_b6);
  assign d_pa3     = 46'(ac3) * 46'(c_b6);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (adv) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_sq   <= d_sq_full[57:12];
      d_ac2t <= d_pa2[45:11];
      d_ac3t <= d_pa3[45:13];
      d_temp <= c_temp;
      d_z    <= c_z;
      d_up   <= c_up;
    end
  end

  // ---- stage E: B2 * SQ, B1 * SQ
  logic signed [62:0] e_pb2, e_pb1;
  logic               e_v, e_z;
  logic signed [51:0] e_b2t;
  logic signed [46:0] e_b1t;
  logic signed [34:0] e_ac2t;
  logic signed [32:0] e_ac3t;
  logic signed [15:0] e_temp;
  logic [15:0]        e_up;

  assign e_pb2 = 63'(b2) * 63'($signed({1'b0, d_sq}));
  assign e_pb1 = 63'(b1) * 63'($signed({1'b0, d_sq}));

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (adv) begin
      e_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_b2t  <= e_pb2[62:11];
      e_b1t  <= e_pb1[62:16];
      e_ac2t <= d_ac2t;
      e_ac3t <= d_ac3t;
      e_temp <= d_temp;
      e_z    <= d_z;
      e_up   <= d_up;
    end
  end

  // ---- stage F: B3 and X3, low 32 bits only are used further on
  logic signed [53:0] f_s3;
  logic signed [47:0] f_s4;
  logic               f_v, f_z;
  logic [31:0]        f_b3, f_x3;
  logic signed [15:0] f_temp;
  logic [15:0]        f_up;

  assign f_s3 = 54'(e_b2t) + 54'(e_ac2t) + (54'(ac1) <<< 2) + 54'sd2;
  assign f_s4 = 48'(e_ac3t) + 48'(e_b1t) + 48'sd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (adv) begin
      f_v <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_b3   <= f_s3[33:2];
      f_x3   <= f_s4[33:2];
      f_temp <= e_temp;
      f_z    <= e_z;
      f_up   <= e_up;
    end
  end

  // ---- stage G: B4 and B7, both modulo 2^32
  logic [31:0]        g_fac, g_b7d;
  logic [47:0]        g_pr4, g_pr7;
  logic [16:0]        g_b4_next;
  logic               g_v, g_z;
  logic [16:0]        g_b4;
  logic [31:0]        g_b7;
  logic signed [15:0] g_temp;

  assign g_fac     = f_x3 + 32'(bpc_pkg::B4_BIAS);
  assign g_pr4     = 48'(ac4) * 48'(g_fac);
  assign g_b4_next = g_pr4[31:15];
  assign g_b7d     = {16'b0, f_up} - f_b3;
  assign g_pr7     = 48'(g_b7d) * 48'(bpc_pkg::B7_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (adv) begin
      g_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_b4   <= g_b4_next;
      g_b7   <= g_pr7[31:0];
      g_z    <= f_z || (g_b4_next == '0);
      g_temp <= f_temp;
    end
  end

  // ---- divider 2: pressure quotient
  localparam int S2W = 1 + 1 + 16;
  logic               d2_v;
  logic [32:0]        d2_q;
  logic [S2W-1:0]     d2_side;
  logic               d2_post, d2_z;
  logic signed [15:0] d2_temp;

  // large B7 divides first and doubles afterwards
  bpc_div #(.NW(33), .DW(17), .SW(S2W)) u_div_press (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (g_v),
    .num      (g_b7[31] ? {1'b0, g_b7} : {g_b7, 1'b0}),
    .den      ((g_b4 == '0) ? 17'd1 : g_b4),
    .side_in  ({g_b7[31], g_z, g_temp}),
    .out_valid(d2_v),
    .quo      (d2_q),
    .side_out (d2_side)
  );

  assign {d2_post, d2_z, d2_temp} = d2_side;

  // ---- stage H: p, (p >> 8)^2, 7357 * p
  logic [33:0]        h_p_next;
  logic [25:0]        h_pp;
  logic               h_v, h_z;
  logic [33:0]        h_p;
  logic [51:0]        h_sq;
  logic [47:0]        h_lin;
  logic signed [15:0] h_temp;

  assign h_p_next = d2_post ? {d2_q, 1'b0} : {1'b0, d2_q};
  assign h_pp     = h_p_next[33:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
    end else if (adv) begin
      h_v <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_p    <= h_p_next;
      h_sq   <= 52'(h_pp) * 52'(h_pp);
      h_lin  <= 48'(h_p_next) * 48'(bpc_pkg::P_LIN_COEF);
      h_temp <= d2_temp;
      h_z    <= d2_z;
    end
  end

  // ---- stage I: correction term
  logic [63:0]        i_t1;
  logic signed [48:0] i_neg;
  logic signed [49:0] i_cs;
  logic               i_v, i_z;
  logic signed [45:0] i_corr;
  logic [33:0]        i_p;
  logic signed [15:0] i_temp;

  assign i_t1  = 64'(h_sq) * 64'(bpc_pkg::P_SQ_COEF);
  assign i_neg = -$signed({1'b0, h_lin});
  assign i_cs  = $signed({2'b0, i_t1[63:16]}) + 50'($signed(i_neg[48:16]))
                 + 50'(bpc_pkg::P_OFFSET);

  always_ff @(posedge clk) begin
    if (rst) begin
      i_v <= 1'b0;
    end else if (adv) begin
      i_v <= h_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_corr <= i_cs[49:4];
      i_p    <= h_p;
      i_temp <= h_temp;
      i_z    <= h_z;
    end
  end

  // ---- final add, saturation, zero-divisor override
  logic signed [47:0] fin_p;

  assign fin_p = $signed({14'b0, i_p}) + 48'(i_corr);

  always_comb begin
    res_next.status             = bpc_pkg::STATUS_OK;
    res_next.temperature_tenths = i_temp;
    if (fin_p < 48'sd0) begin
      res_next.pressure_pa = '0;
    end else if (fin_p > 48'(bpc_pkg::PRESS_MAX)) begin
      res_next.pressure_pa = 18'(bpc_pkg::PRESS_MAX);
    end else begin
      res_next.pressure_pa = fin_p[17:0];
    end
    if (i_z) begin
      res_next.status             = bpc_pkg::STATUS_DIV_ZERO;
      res_next.temperature_tenths = '0;
      res_next.pressure_pa        = '0;
    end
  end

  // ---- output queue
  assign push = adv && i_v;
  assign pop  = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
      q_wr    <= 1'b0;
      q_rd    <= 1'b0;
    end else begin
      q_count <= q_count + 2'(push) - 2'(pop);
      if (push) begin
        q_wr <= ~q_wr;
      end
      if (pop) begin
        q_rd <= ~q_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[q_wr] <= res_next;
    end
  end

  assign result.valid              = (q_count != '0);
  assign result.temperature_tenths = q_mem[q_rd].temperature_tenths;
  assign result.pressure_pa        = q_mem[q_rd].pressure_pa;
  assign result.status             = q_mem[q_rd].status;

endmodule

[rtl/bpc_div.sv]
// ---------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, sideband carried.
// ---------------------------------------------------------------------------
module bpc_div #(
  parameter int NW = 27,
  parameter int DW = 20,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic          v   [NW];
  logic [DW-1:0] rem [NW];
  logic [NW-1:0] nq  [NW];
  logic [DW-1:0] dv  [NW];
  logic [SW-1:0] sd  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] r_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] d_in;
    logic [SW-1:0] s_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in  = in_valid;
      assign r_in  = '0;
      assign nq_in = num;
      assign d_in  = den;
      assign s_in  = side_in;
    end else begin : g_rest
      assign v_in  = v[k-1];
      assign r_in  = rem[k-1];
      assign nq_in = nq[k-1];
      assign d_in  = dv[k-1];
      assign s_in  = sd[k-1];
    end

    // partial remainder stays below the divisor, so DW bits hold it
    assign trial = {r_in, nq_in[NW-1]};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv) begin
        v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k] <= ge ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
        nq[k]  <= {nq_in[NW-2:0], ge};
        dv[k]  <= d_in;
        sd[k]  <= s_in;
      end
    end
  end

  assign out_valid = v[NW-1];
  assign quo       = nq[NW-1];
  assign side_out  = sd[NW-1];

endmodule

[rtl/bpc_chk.sv]
// ---------------------------------------------------------------------------
// Barometric pressure compensation checker
// Port-level properties of the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "barometric_pressure_compensation_macros.svh"

module bpc_chk (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic signed [15:0] res_temp,
  input logic [17:0]        res_press,
  input logic               res_status
);

  // a zero divisor must come with both values cleared
  `BPC_ASSERT(a_div_zero_clears, res_valid && res_status == bpc_pkg::STATUS_DIV_ZERO, res_temp == '0 && res_press == '0, "zero-divisor result carries nonzero values")

  // nothing pending right after reset
  `BPC_ASSERT_ALWAYS(a_reset_empty, rst, !res_valid, "result valid after reset")

  // a result that is not taken stays offered
  `BPC_ASSERT_NEXT(a_valid_holds, res_valid && !res_ready, res_valid, "result dropped before transfer")

endmodule

bind barometric_pressure_compensation bpc_chk u_bpc_chk (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_temp  (result.temperature_tenths),
  .res_press (result.pressure_pa),
  .res_status(result.status)
);
